/* rtl/hgcl_pkg.sv */
// Shared types, widths, register indexes and helpers for the hex grid cell locator.
// Used by every other file of the block but hgcl_stream_if; depends on nothing.
`default_nettype none
package hgcl_pkg;

	localparam int DimW  = 13;
	localparam int OffW  = 12;
	localparam int LocW  = 24;
	localparam int CellW = 16;
	localparam int OrgW  = 32;
	localparam int IdxW  = 3;

	// Divider geometry: the smallest divisor is 128, so a 23-bit magnitude gives 16 quotient bits.
	localparam int NumW  = LocW - 1;
	localparam int QuoW  = 16;
	localparam int DenW  = 21;
	localparam int NDiv  = QuoW;

	localparam logic [IdxW-1:0] REG_TILE_WIDTH   = 3'd0;
	localparam logic [IdxW-1:0] REG_TILE_HEIGHT  = 3'd1;
	localparam logic [IdxW-1:0] REG_SIDE_LENGTH  = 3'd2;
	localparam logic [IdxW-1:0] REG_STAGGER_AXIS = 3'd3;
	localparam logic [IdxW-1:0] REG_STAGGER_EVEN = 3'd4;

	localparam logic [DimW-1:0] TILE_WIDTH_RST  = 13'd64;
	localparam logic [DimW-1:0] TILE_HEIGHT_RST = 13'd56;
	localparam logic [DimW-1:0] SIDE_LENGTH_RST = 13'd32;
	localparam logic [DimW-1:0] TILE_MAX        = 13'd4096;

	typedef struct packed {
		logic                    func;
		logic signed [LocW-1:0]  loc_x;
		logic signed [LocW-1:0]  loc_y;
		logic signed [CellW-1:0] cell_x;
		logic signed [CellW-1:0] cell_y;
	} in_word_t;

	typedef struct packed {
		logic signed [CellW-1:0] found_x;
		logic signed [CellW-1:0] found_y;
		logic signed [OrgW-1:0]  origin_x;
		logic signed [OrgW-1:0]  origin_y;
		logic                    saturated;
	} out_word_t;

	typedef struct packed {
		logic                    func;
		logic                    neg_a;
		logic                    neg_b;
		logic signed [CellW-1:0] c_along;
		logic signed [CellW-1:0] c_across;
	} side_t;

	function automatic logic [DimW-1:0] eff_tile(input logic [DimW-1:0] raw);
		logic [DimW-1:0] r;
		if (raw == '0) begin
			r = 13'd1;
		end else if (raw > TILE_MAX) begin
			r = TILE_MAX;
		end else begin
			r = raw;
		end
		return r;
	endfunction

endpackage
`default_nettype wire

/* rtl/hgcl_stream_if.sv */
// Valid/ready stream interface that carries one word per handshake.
// The word type comes from hgcl_pkg through the type parameter.
`default_nettype none
interface hgcl_stream_if #(parameter type data_t = logic);
	logic  valid;
	logic  ready;
	data_t data;
	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/hex_grid_cell_locator_unit.sv */
// Hex grid cell locator: pixel location to offset cell, and cell to pixel origin.
// Depends on hgcl_pkg, hgcl_stream_if and hgcl_div.
//
// Channels: req carries one in_word_t per handshake, rsp returns one out_word_t
// for every accepted word, in order. A word is taken when valid and ready are
// both high at a rising edge of clk. Configuration is written through wr_en,
// reg_index and wr_data only while the block holds no word; the user must keep
// to this, as the block itself does not enforce it. A word passes through 21
// register stages: an input register, sixteen stages of the two restoring dividers
// (one quotient bit each), then stages for sign fix-up, the edge multiplications,
// the slanted-edge decision and the clamped output register. Throughput is one
// word per cycle unless the receiver holds rsp.ready low.
// When the receiver holds rsp.ready low, words close up behind the output
// register; req.ready falls only once every stage holds a word.
// arst_n clears all valid bits and restores the register reset values.
// Tile width or height of zero acts as one, above 4096 as 4096.
`default_nettype none
module hex_grid_cell_locator_unit (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         wr_en,
	input  wire logic [hgcl_pkg::IdxW-1:0]    reg_index,
	input  wire logic [hgcl_pkg::DimW-1:0]    wr_data,
	hgcl_stream_if.sink                       req,
	hgcl_stream_if.source                     rsp
);
	localparam int NDiv = hgcl_pkg::NDiv;
	localparam int NStg = NDiv + 5;
	localparam int DimW = hgcl_pkg::DimW;
	localparam int OffW = hgcl_pkg::OffW;
	localparam int DenW = hgcl_pkg::DenW;
	localparam int NumW = hgcl_pkg::NumW;
	localparam int QuoW = hgcl_pkg::QuoW;
	localparam int CellW = hgcl_pkg::CellW;
	localparam int OrgW = hgcl_pkg::OrgW;
	localparam int LocW = hgcl_pkg::LocW;
	localparam int QW   = QuoW + 2;
	localparam int MulW = 34;
	localparam int PrdW = CellW + DimW + 1;
	localparam int ThrW = OffW + DimW;

	function automatic logic [CellW:0] clamp16(input logic signed [QW-1:0] v);
		logic [CellW:0] r;
		if (v < -$signed(QW'(32768))) begin
			r = {1'b1, 16'h8000};
		end else if (v > $signed(QW'(32767))) begin
			r = {1'b1, 16'h7fff};
		end else begin
			r = {1'b0, v[CellW-1:0]};
		end
		return r;
	endfunction

	// Configuration registers.
	logic [DimW-1:0] tile_width_q, tile_height_q, side_length_q;
	logic            stagger_axis_q, stagger_even_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_width_q   <= hgcl_pkg::TILE_WIDTH_RST;
			tile_height_q  <= hgcl_pkg::TILE_HEIGHT_RST;
			side_length_q  <= hgcl_pkg::SIDE_LENGTH_RST;
			stagger_axis_q <= 1'b0;
			stagger_even_q <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_index)
				hgcl_pkg::REG_TILE_WIDTH:   tile_width_q   <= wr_data;
				hgcl_pkg::REG_TILE_HEIGHT:  tile_height_q  <= wr_data;
				hgcl_pkg::REG_SIDE_LENGTH:  side_length_q  <= wr_data;
				hgcl_pkg::REG_STAGGER_AXIS: stagger_axis_q <= wr_data[0];
				hgcl_pkg::REG_STAGGER_EVEN: stagger_even_q <= wr_data[0];
				default: ;
			endcase
		end
	end

	// Geometry derived from the registers, settled before any word arrives.
	logic [DimW-1:0] w_eff, h_eff, dim_a_c, dim_b_c, diff_c;
	logic [OffW-1:0] off_c;
	logic [DimW-1:0] dim_b_q, pitch_q;
	logic [OffW-1:0] off_q;
	logic [DenW-1:0] den_a_q, den_b_q;
	logic [MulW-1:0] thr_q;

	assign w_eff   = hgcl_pkg::eff_tile(tile_width_q);
	assign h_eff   = hgcl_pkg::eff_tile(tile_height_q);
	assign dim_a_c = stagger_axis_q ? h_eff : w_eff;
	assign dim_b_c = stagger_axis_q ? w_eff : h_eff;
	assign diff_c  = dim_a_c - side_length_q;
	assign off_c   = (side_length_q >= dim_a_c) ? '0 : diff_c[DimW-1:1];

	always_ff @(posedge clk) begin
		dim_b_q <= dim_b_c;
		off_q   <= off_c;
		pitch_q <= dim_a_c - DimW'(off_c);
		den_a_q <= {dim_a_c - DimW'(off_c), 8'd0};
		den_b_q <= DenW'({dim_b_c, 7'd0});
		thr_q   <= MulW'({ThrW'(off_q) * ThrW'(dim_b_q), 8'd0});
	end

	// Stall chain: a stage moves on unless it and every stage after it is full and rsp.ready is low.
	logic [NStg-1:0] en, vld_q;

	for (genvar k = 0; k < NStg; k++) begin : g_vld
		assign en[k] = !(&vld_q[NStg-1:k]) || rsp.ready;
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				vld_q[k] <= 1'b0;
			end else if (en[k]) begin
				if (k == 0) begin
					vld_q[k] <= req.valid;
				end else begin
					vld_q[k] <= vld_q[(k == 0) ? 0 : k-1];
				end
			end
		end
	end

	assign req.ready = en[0];
	assign rsp.valid = vld_q[NStg-1];

	// Input register.
	hgcl_pkg::in_word_t in_s1;
	always_ff @(posedge clk) begin
		if (en[0]) begin
			in_s1 <= req.data;
		end
	end

	logic signed [LocW-1:0] la_c, lb_c;
	logic [NumW-1:0]        num_a, num_b;
	hgcl_pkg::side_t        side_c;

	assign la_c  = stagger_axis_q ? in_s1.loc_y : in_s1.loc_x;
	assign lb_c  = stagger_axis_q ? in_s1.loc_x : in_s1.loc_y;
	assign num_a = la_c[LocW-1] ? ~la_c[NumW-1:0] : la_c[NumW-1:0];
	assign num_b = lb_c[LocW-1] ? ~lb_c[NumW-1:0] : lb_c[NumW-1:0];

	always_comb begin
		side_c.func     = in_s1.func;
		side_c.neg_a    = la_c[LocW-1];
		side_c.neg_b    = lb_c[LocW-1];
		side_c.c_along  = stagger_axis_q ? in_s1.cell_y : in_s1.cell_x;
		side_c.c_across = stagger_axis_q ? in_s1.cell_x : in_s1.cell_y;
	end

	// Floor division by the line pitch and by the half tile.
	logic [QuoW-1:0] quo_a, quo_b;
	logic [DenW-1:0] rem_a, rem_b;

	hgcl_div u_div_a (
		.clk (clk), .en (en[NDiv:1]), .num (num_a), .den (den_a_q), .quo (quo_a), .rem (rem_a)
	);
	hgcl_div u_div_b (
		.clk (clk), .en (en[NDiv:1]), .num (num_b), .den (den_b_q), .quo (quo_b), .rem (rem_b)
	);

	hgcl_pkg::side_t side_sd [NDiv];
	for (genvar j = 0; j < NDiv; j++) begin : g_side
		always_ff @(posedge clk) begin
			if (en[j+1]) begin
				side_sd[j] <= (j == 0) ? side_c : side_sd[(j == 0) ? 0 : j-1];
			end
		end
	end

	// Sign fix-up: a negative dividend was divided as its complement.
	logic signed [QW-1:0] qa_s2, qb_s2;
	logic [DenW-1:0]      ra_s2, rb_s2;
	hgcl_pkg::side_t      side_s2;

	always_ff @(posedge clk) begin
		if (en[NDiv+1]) begin
			side_s2 <= side_sd[NDiv-1];
			qa_s2   <= side_sd[NDiv-1].neg_a ? ~{2'b00, quo_a} : {2'b00, quo_a};
			qb_s2   <= side_sd[NDiv-1].neg_b ? ~{2'b00, quo_b} : {2'b00, quo_b};
			ra_s2   <= side_sd[NDiv-1].neg_a ? den_a_q - DenW'(1) - rem_a : rem_a;
			rb_s2   <= side_sd[NDiv-1].neg_b ? den_b_q - DenW'(1) - rem_b : rem_b;
		end
	end

	// Cross products for the slanted edges, and the origin products.
	logic                 ident_c;
	logic [QW-1:0]        bm_c;
	logic signed [QW-1:0] a_s3, b_s3;
	logic [MulW-1:0]      lhs_s3, rhs_s3;
	logic                 zone_s3, ident_s3, beven_s3, half_s3;
	logic signed [PrdW-1:0] along_s3, across_s3;
	hgcl_pkg::side_t      side_s3;

	assign ident_c = (stagger_even_q == !qa_s2[0]);
	assign bm_c    = qb_s2 - QW'(ident_c);

	always_ff @(posedge clk) begin
		if (en[NDiv+2]) begin
			side_s3   <= side_s2;
			a_s3      <= qa_s2;
			b_s3      <= {bm_c[QW-1], bm_c[QW-1:1]};
			ident_s3  <= ident_c;
			beven_s3  <= !qb_s2[0];
			zone_s3   <= ra_s2 < DenW'({off_q, 8'd0});
			lhs_s3    <= MulW'(ra_s2 * dim_b_q);
			rhs_s3    <= MulW'(rb_s2 * {off_q, 1'b0});
			along_s3  <= PrdW'(side_s2.c_along * $signed({1'b0, pitch_q}));
			across_s3 <= PrdW'(side_s2.c_across * $signed({1'b0, dim_b_q}));
			half_s3   <= (stagger_even_q == !side_s2.c_along[0]);
		end
	end

	// Edge decision.
	logic            diag_c, low_c, dec_a, inc_b, dec_b;
	logic [MulW-1:0] sum_c;
	logic signed [QW-1:0]   a_s4, b_s4;
	logic signed [OrgW-1:0] along_s4, across_s4;
	hgcl_pkg::side_t        side_s4;

	assign diag_c = lhs_s3 < rhs_s3;
	assign sum_c  = lhs_s3 + rhs_s3;
	assign low_c  = sum_c < thr_q;

	always_comb begin
		dec_a = 1'b0;
		inc_b = 1'b0;
		dec_b = 1'b0;
		if (zone_s3) begin
			if (ident_s3) begin
				if (beven_s3) begin
					dec_a = diag_c;
					inc_b = diag_c;
				end else begin
					dec_a = low_c;
				end
			end else begin
				if (beven_s3) begin
					dec_a = low_c;
					dec_b = low_c;
				end else begin
					dec_a = diag_c;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en[NDiv+3]) begin
			side_s4   <= side_s3;
			a_s4      <= a_s3 - QW'(dec_a);
			b_s4      <= b_s3 + QW'(inc_b) - QW'(dec_b);
			along_s4  <= OrgW'(along_s3);
			across_s4 <= OrgW'(across_s3) + (half_s3 ? OrgW'(dim_b_q[DimW-1:1]) : '0);
		end
	end

	// Output register with clamping.
	logic [CellW:0]     cx_c, cy_c;
	hgcl_pkg::out_word_t out_c, out_s5;

	assign cx_c = clamp16(stagger_axis_q ? b_s4 : a_s4);
	assign cy_c = clamp16(stagger_axis_q ? a_s4 : b_s4);

	always_comb begin
		out_c = '0;
		if (side_s4.func) begin
			out_c.origin_x = stagger_axis_q ? across_s4 : along_s4;
			out_c.origin_y = stagger_axis_q ? along_s4 : across_s4;
		end else begin
			out_c.found_x   = cx_c[CellW-1:0];
			out_c.found_y   = cy_c[CellW-1:0];
			out_c.saturated = cx_c[CellW] | cy_c[CellW];
		end
	end

	always_ff @(posedge clk) begin
		if (en[NStg-1]) begin
			out_s5 <= out_c;
		end
	end

	assign rsp.data = out_s5;
endmodule
`default_nettype wire

/* rtl/hgcl_div.sv */
// Pipelined restoring divider: one quotient bit per register stage.
// Uses widths from hgcl_pkg; stage enables come from the top level's stall chain.
`default_nettype none
module hgcl_div (
	input  wire logic                       clk,
	input  wire logic [hgcl_pkg::NDiv-1:0]  en,
	input  wire logic [hgcl_pkg::NumW-1:0]  num,
	input  wire logic [hgcl_pkg::DenW-1:0]  den,
	output logic      [hgcl_pkg::QuoW-1:0]  quo,
	output logic      [hgcl_pkg::DenW-1:0]  rem
);
	localparam int NDiv = hgcl_pkg::NDiv;
	localparam int QuoW = hgcl_pkg::QuoW;
	localparam int DenW = hgcl_pkg::DenW;
	localparam int NumW = hgcl_pkg::NumW;

	logic [DenW-1:0] rem_sd [NDiv];
	logic [QuoW-1:0] qs_sd  [NDiv];

	for (genvar j = 0; j < NDiv; j++) begin : g_step
		logic [DenW-1:0] rem_in;
		logic [QuoW-1:0] qs_in;
		logic [DenW:0]   trial;
		logic            ge;
		if (j == 0) begin : g_first
			assign rem_in = DenW'(num[NumW-1:QuoW]);
			assign qs_in  = num[QuoW-1:0];
		end else begin : g_next
			assign rem_in = rem_sd[j-1];
			assign qs_in  = qs_sd[j-1];
		end
		assign trial = {rem_in, qs_in[QuoW-1]};
		assign ge    = trial >= {1'b0, den};
		always_ff @(posedge clk) begin
			if (en[j]) begin
				rem_sd[j] <= ge ? DenW'(trial - {1'b0, den}) : DenW'(trial);
				qs_sd[j]  <= {qs_in[QuoW-2:0], ge};
			end
		end
	end

	assign quo = qs_sd[NDiv-1];
	assign rem = rem_sd[NDiv-1];
endmodule
`default_nettype wire

/* rtl/hgcl_chk.sv */
// Port-level checks for the hex grid cell locator, bound to the top level.
// Depends on hgcl_pkg for the result word type.
`default_nettype none
module hgcl_chk (
	input wire logic                clk,
	input wire logic                arst_n,
	input wire logic                req_ready,
	input wire logic                rsp_valid,
	input wire logic                rsp_ready,
	input wire hgcl_pkg::out_word_t rsp_data
);
	logic at_edge;

	assign at_edge = (rsp_data.found_x == 16'h8000) || (rsp_data.found_x == 16'h7fff) ||
		(rsp_data.found_y == 16'h8000) || (rsp_data.found_y == 16'h7fff);

	a_ready_only_when_full: assert property (@(posedge clk) disable iff (!arst_n)
		!req_ready |-> (rsp_valid && !rsp_ready))
		else $error("input stalled while the output was free");

	a_valid_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid)
		else $error("result word dropped while stalled");

	a_data_holds: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(rsp_data))
		else $error("result word changed while stalled");

	a_sat_at_limit: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_data.saturated |-> at_edge)
		else $error("saturation flagged on a cell inside the range");
endmodule

bind hex_grid_cell_locator_unit hgcl_chk u_hgcl_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);
`default_nettype wire

/* dv/hgcl_locator_checker.sv */
// Checker for the hex grid cell locator: watches both channels and the register writes,
// predicts every response word and compares it with what the block returns.
// Depends on hgcl_pkg.
module hgcl_locator_checker
	import hgcl_pkg::*;
(
	input  logic                clk,
	input  logic                arst_n,
	input  logic                wr_en,
	input  logic [IdxW-1:0]     reg_index,
	input  logic [DimW-1:0]     wr_data,
	input  logic                req_valid,
	input  logic                req_ready,
	input  in_word_t            req_data,
	input  logic                rsp_valid,
	input  logic                rsp_ready,
	input  out_word_t           rsp_data,
	output int                  fail_count,
	output int                  pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic [DimW-1:0] tile_w_reg, tile_h_reg, side_reg;
	logic            axis_reg, even_reg;
	out_word_t       expected_words[$];

	function automatic longint floor_div(longint a, longint d);
		longint q;
		q = a / d;
		if ((a % d) != 0 && a < 0) begin
			q--;
		end
		return q;
	endfunction

	function automatic longint tile_dim(logic [DimW-1:0] raw);
		longint r;
		r = raw;
		if (raw == '0) begin
			r = 1;
		end else if (raw > 4096) begin
			r = 4096;
		end
		return r;
	endfunction

	function automatic longint edge_offset(longint dim);
		longint s;
		s = side_reg;
		if (s >= dim) begin
			return 0;
		end
		return (dim - s) / 2;
	endfunction

	function automatic void find_cell(longint la, longint lb, longint dim_a, longint dim_b,
			output longint fa, output longint fb);
		longint off, pa, hb, qa, ra, qb, rb, lhs, rhs;
		logic   same, diag, low;
		off  = edge_offset(dim_a);
		pa   = (dim_a - off) * 256;
		hb   = dim_b * 128;
		qa   = floor_div(la, pa);
		ra   = la - qa * pa;
		qb   = floor_div(lb, hb);
		rb   = lb - qb * hb;
		same = (even_reg == !qa[0]);
		fa   = qa;
		fb   = qb;
		if (same) begin
			fb--;
		end
		fb = floor_div(fb, 2);
		if (ra < off * 256) begin
			lhs  = ra * dim_b;
			rhs  = rb * 2 * off;
			diag = lhs < rhs;
			low  = (lhs + rhs) < 256 * off * dim_b;
			if (same) begin
				if (!qb[0]) begin
					if (diag) begin
						fa--;
						fb++;
					end
				end else if (low) begin
					fa--;
				end
			end else begin
				if (!qb[0]) begin
					if (low) begin
						fa--;
						fb--;
					end
				end else if (diag) begin
					fa--;
				end
			end
		end
	endfunction

	function automatic longint clamp_cell(longint v, inout logic sat);
		if (v < -32768) begin
			sat = 1'b1;
			return -32768;
		end
		if (v > 32767) begin
			sat = 1'b1;
			return 32767;
		end
		return v;
	endfunction

	function automatic out_word_t predict_word(in_word_t w);
		out_word_t r;
		longint    tw, th, fx, fy, ox, oy, cx, cy;
		logic      sat;
		tw  = tile_dim(tile_w_reg);
		th  = tile_dim(tile_h_reg);
		sat = 1'b0;
		fx  = 0;
		fy  = 0;
		ox  = 0;
		oy  = 0;
		if (!w.func) begin
			if (!axis_reg) begin
				find_cell(longint'(w.loc_x), longint'(w.loc_y), tw, th, fx, fy);
			end else begin
				find_cell(longint'(w.loc_y), longint'(w.loc_x), th, tw, fy, fx);
			end
			fx = clamp_cell(fx, sat);
			fy = clamp_cell(fy, sat);
		end else begin
			cx = longint'(w.cell_x);
			cy = longint'(w.cell_y);
			if (!axis_reg) begin
				ox = cx * (tw - edge_offset(tw));
				oy = cy * th;
				if (even_reg == !w.cell_x[0]) begin
					oy += th / 2;
				end
			end else begin
				ox = cx * tw;
				oy = cy * (th - edge_offset(th));
				if (even_reg == !w.cell_y[0]) begin
					ox += tw / 2;
				end
			end
		end
		r.found_x   = fx[CellW-1:0];
		r.found_y   = fy[CellW-1:0];
		r.origin_x  = ox[OrgW-1:0];
		r.origin_y  = oy[OrgW-1:0];
		r.saturated = sat;
		return r;
	endfunction

	assign pending = expected_words.size();

	always @(posedge clk or negedge arst_n) begin
		out_word_t exp_w;
		if (!arst_n) begin
			tile_w_reg <= TILE_WIDTH_RST;
			tile_h_reg <= TILE_HEIGHT_RST;
			side_reg   <= SIDE_LENGTH_RST;
			axis_reg   <= 1'b0;
			even_reg   <= 1'b0;
			fail_count <= 0;
			expected_words.delete();
		end else begin
			if (req_valid && req_ready) begin
				expected_words.insert(expected_words.size(), predict_word(req_data));
			end
			if (rsp_valid && rsp_ready) begin
				if (expected_words.size() == 0) begin
					if (fail_count < 10) begin
						$display("unexpected response word %p", rsp_data);
					end
					fail_count <= fail_count + 1;
				end else begin
					exp_w = expected_words.pop_front();
					if (rsp_data !== exp_w) begin
						if (fail_count < 10) begin
							$display("mismatch: expected %p, got %p", exp_w, rsp_data);
						end
						fail_count <= fail_count + 1;
					end
				end
			end
			if (wr_en) begin
				case (reg_index)
					REG_TILE_WIDTH: begin
						tile_w_reg <= wr_data;
					end
					REG_TILE_HEIGHT: begin
						tile_h_reg <= wr_data;
					end
					REG_SIDE_LENGTH: begin
						side_reg <= wr_data;
					end
					REG_STAGGER_AXIS: begin
						axis_reg <= wr_data[0];
					end
					REG_STAGGER_EVEN: begin
						even_reg <= wr_data[0];
					end
					default: begin
					end
				endcase
			end
		end
	end
endmodule

/* dv/hex_grid_cell_locator_unit_tb.sv */
// Top of the hex grid cell locator testbench: clock, reset, register settings,
// request stimulus, response stalls and the verdict. Depends on hgcl_pkg,
// hgcl_stream_if, hgcl_locator_checker and the block itself.
module hex_grid_cell_locator_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;
	import hgcl_pkg::*;

	logic            clk;
	logic            arst_n;
	logic            wr_en;
	logic [IdxW-1:0] reg_index;
	logic [DimW-1:0] wr_data;
	int              fail_count;
	int              pending;
	int              sender_idle_pct;
	int              recv_stall_pct;
	int              hold_off;
	int              quiet_cycles;

	hgcl_stream_if #(.data_t(in_word_t))  req_ch ();
	hgcl_stream_if #(.data_t(out_word_t)) rsp_ch ();

	hex_grid_cell_locator_unit u_dut (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .reg_index(reg_index),
		.wr_data(wr_data), .req(req_ch.sink), .rsp(rsp_ch.source)
	);

	hgcl_locator_checker u_checker (
		.clk(clk), .arst_n(arst_n), .wr_en(wr_en), .reg_index(reg_index),
		.wr_data(wr_data), .req_valid(req_ch.valid), .req_ready(req_ch.ready),
		.req_data(req_ch.data), .rsp_valid(rsp_ch.valid), .rsp_ready(rsp_ch.ready),
		.rsp_data(rsp_ch.data), .fail_count(fail_count), .pending(pending)
	);

	initial begin
		clk = 1'b0;
		forever begin
			#5 clk = ~clk;
		end
	end

	// The receiver stalls at random, or for a long stretch while hold_off counts down.
	always @(negedge clk) begin
		if (hold_off > 0) begin
			rsp_ch.ready <= 1'b0;
			hold_off     <= hold_off - 1;
		end else begin
			rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
		end
	end

	always @(posedge clk) begin
		if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready) || wr_en) begin
			quiet_cycles <= 0;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
		if (quiet_cycles > 20000) begin
			$display("hex_grid_cell_locator_unit test failed");
			$finish;
		end
	end

	task automatic write_reg(logic [IdxW-1:0] idx, logic [DimW-1:0] val);
		@(negedge clk);
		wr_en     <= 1'b1;
		reg_index <= idx;
		wr_data   <= val;
		@(negedge clk);
		wr_en <= 1'b0;
	endtask

	task automatic set_grid(int tw, int th, int sl, int ax, int ev);
		write_reg(REG_TILE_WIDTH, DimW'(tw));
		write_reg(REG_TILE_HEIGHT, DimW'(th));
		write_reg(REG_SIDE_LENGTH, DimW'(sl));
		write_reg(REG_STAGGER_AXIS, DimW'(ax));
		write_reg(REG_STAGGER_EVEN, DimW'(ev));
	endtask

	// Offers one word, holding it until the block takes it.
	task automatic send_word(in_word_t w);
		while ($urandom_range(99) < sender_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.data  <= w;
		@(posedge clk);
		while (!req_ch.ready) begin
			@(posedge clk);
		end
		@(negedge clk);
	endtask

	function automatic in_word_t random_word();
		in_word_t w;
		int       mode;
		w    = '0;
		mode = $urandom_range(9);
		w.func   = 1'($urandom_range(1));
		w.cell_x = 16'($urandom());
		w.cell_y = 16'($urandom());
		w.loc_x  = 24'($urandom());
		w.loc_y  = 24'($urandom());
		if (mode < 6) begin
			w.loc_x  = $signed(24'($urandom_range(40000))) - 24'sd20000;
			w.loc_y  = $signed(24'($urandom_range(40000))) - 24'sd20000;
			w.cell_x = $signed(16'($urandom_range(200))) - 16'sd100;
			w.cell_y = $signed(16'($urandom_range(200))) - 16'sd100;
		end
		return w;
	endfunction

	task automatic drain();
		@(negedge clk);
		req_ch.valid <= 1'b0;
		while (pending != 0 || hold_off != 0) begin
			@(negedge clk);
		end
		repeat (30) @(negedge clk);
	endtask

	task automatic random_phase(int n, int idle, int stall);
		sender_idle_pct = idle;
		recv_stall_pct  = stall;
		repeat (n) begin
			send_word(random_word());
		end
		drain();
	endtask

	initial begin
		in_word_t w;
		arst_n          = 1'b0;
		wr_en           = 1'b0;
		reg_index       = '0;
		wr_data         = '0;
		req_ch.valid    = 1'b0;
		req_ch.data     = '0;
		rsp_ch.ready    = 1'b0;
		hold_off        = 0;
		quiet_cycles    = 0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed words on the reset grid: field extremes, both functions, overflow.
		for (int i = 0; i < 20; i++) begin
			w        = '0;
			w.func   = i[0];
			w.loc_x  = (i % 4 < 2) ? 24'sh7FFFFF : 24'sh800000;
			w.loc_y  = (i % 8 < 4) ? 24'sh800000 : 24'sh7FFFFF;
			w.cell_x = (i % 4 < 2) ? 16'sh7FFF : 16'sh8000;
			w.cell_y = (i % 8 < 4) ? 16'sh8000 : 16'sh7FFF;
			if (i >= 8) begin
				w.loc_x  = 24'((i - 12) * 3000);
				w.loc_y  = 24'((12 - i) * 2100);
				w.cell_x = 16'(i - 13);
				w.cell_y = 16'(13 - i);
			end
			send_word(w);
		end
		drain();

		random_phase(100, 0, 0);
		set_grid(0, 0, 0, 1, 1);
		random_phase(80, 53, 0);
		set_grid(8191, 4096, 4096, 0, 1);
		random_phase(80, 0, 53);
		set_grid(1, 8191, 8191, 1, 0);
		random_phase(80, 22, 22);
		set_grid(48, 40, 20, 1, 1);
		random_phase(100, 0, 0);
		set_grid(7, 9, 1, 0, 1);
		random_phase(100, 53, 53);

		// The response side holds off while words keep arriving, so the pipeline fills.
		hold_off = 200;
		set_grid(64, 56, 32, 0, 0);
		random_phase(140, 0, 0);

		if (fail_count == 0) begin
			$display("hex_grid_cell_locator_unit test passed");
		end else begin
			$display("hex_grid_cell_locator_unit test failed");
		end
		$finish;
	end
endmodule
